>>> rtl/frequency_ordered_rank_table_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the frequency ordered rank table
// Concurrent checks on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef FREQUENCY_ORDERED_RANK_TABLE_MACROS_SVH
`define FREQUENCY_ORDERED_RANK_TABLE_MACROS_SVH

// expression must hold at every edge
`define FROT_ASSERT(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// consequent must hold whenever the antecedent does
`define FROT_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

>>> rtl/frot_pkg.sv
// ----------------------------------------------------------------------------
// frot_pkg
// Shared types and codes of the frequency ordered rank table.
// ----------------------------------------------------------------------------
package frot_pkg;

    localparam int FIELD_W        = 11;
    localparam int KIND_W         = 2;
    localparam int NUM_VALUES_DEF = 1024;

    localparam logic [KIND_W-1:0] KIND_INC   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DEC   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_QUERY = 2'd2;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [FIELD_W-1:0] value;
        logic [FIELD_W-1:0] min_count;
        logic [FIELD_W-1:0] rank;
    } req_t;

    typedef struct packed {
        logic               found;
        logic [FIELD_W-1:0] answer_value;
    } rsp_t;

    typedef struct packed {
        logic ready;
        logic res_valid;
    } frot_stat_t;

endpackage

>>> rtl/frot_engine.sv
// ----------------------------------------------------------------------------
// frot_engine
// Sequencer over the value and position memories: count updates by swap,
// rank queries by bucket start lookup, and the clearing pass after reset.
// ----------------------------------------------------------------------------
`include "frequency_ordered_rank_table_macros.svh"

module frot_engine #(
    parameter int NUM_VALUES = frot_pkg::NUM_VALUES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    input  frot_pkg::req_t      req_data,
    input  logic                res_take,
    output frot_pkg::frot_stat_t stat,
    output frot_pkg::rsp_t      res
);
    import frot_pkg::*;

    localparam int AW = $clog2(NUM_VALUES);
    localparam int PW = $clog2(NUM_VALUES + 2);
    localparam int CW = $clog2(NUM_VALUES + 1);
    localparam int XW = ((PW > FIELD_W) ? PW : FIELD_W) + 1;
    localparam logic [XW-1:0] N_X = XW'(NUM_VALUES);

    typedef struct packed {
        logic [PW-1:0] pos;
        logic [CW-1:0] cnt;
    } vm_entry_t;

    typedef struct packed {
        logic [PW-1:0] val;
        logic [PW-1:0] bs;
    } pm_entry_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_FETCH,
        S_BUCKET,
        S_SWAP,
        S_FIX,
        S_QREAD,
        S_OUT
    } state_t;

    function automatic logic [AW-1:0] to_addr(input logic [XW-1:0] x);
        return AW'(x - XW'(1));
    endfunction

    // value indexed: position and count; second memory: value by position, bucket start by count
    vm_entry_t vm_mem [0:NUM_VALUES-1];
    pm_entry_t pm_mem [0:NUM_VALUES-1];

    vm_entry_t vm_rdata_reg;
    pm_entry_t pm_rdata_reg;
    logic [AW-1:0] vm_raddr, pm_raddr, vm_waddr, pm_waddr;
    vm_entry_t vm_wdata;
    pm_entry_t pm_wdata;
    logic vm_we_pos, vm_we_cnt, pm_we_val, pm_we_bs;

    state_t             state_reg, state_next;
    logic [AW-1:0]      clr_reg, clr_next;
    logic [KIND_W-1:0]  kind_reg, kind_next;
    logic [FIELD_W-1:0] value_reg, value_next;
    logic [FIELD_W-1:0] min_reg, min_next;
    logic [FIELD_W-1:0] rank_reg, rank_next;
    logic [PW-1:0]      here_reg, here_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic [PW-1:0]      target_reg, target_next;
    logic [PW-1:0]      other_reg, other_next;
    rsp_t               res_reg, res_next;

    logic          inc;
    logic [XW-1:0] req_v_x, fetch_cnt_x, b_fetch_x, cnt_x, b_x, bs_x, target_x;
    logic [XW-1:0] min_x, start_x, pos_x;
    logic          target_ok;
    logic [PW-1:0] new_bs;
    logic [CW-1:0] new_cnt;

    assign inc         = (kind_reg == KIND_INC);
    assign req_v_x     = XW'(req_data.value);
    assign fetch_cnt_x = XW'(vm_rdata_reg.cnt);
    assign b_fetch_x   = inc ? fetch_cnt_x + XW'(1) : fetch_cnt_x;
    assign cnt_x       = XW'(cnt_reg);
    assign b_x         = inc ? cnt_x + XW'(1) : cnt_x;
    assign bs_x        = XW'(pm_rdata_reg.bs);
    assign target_x    = inc ? bs_x - XW'(1) : bs_x;
    assign target_ok   = (target_x != '0) && (target_x <= N_X);
    assign new_bs      = inc ? PW'(target_x) : PW'(target_x + XW'(1));
    assign new_cnt     = inc ? CW'(cnt_x + XW'(1)) : CW'(cnt_x - XW'(1));
    assign min_x       = XW'(min_reg);
    assign start_x     = (min_x == '0) ? XW'(1) :
                         (min_x > N_X) ? N_X + XW'(1) : bs_x;
    assign pos_x       = start_x + XW'(rank_reg) - XW'(1);

    assign stat.ready     = (state_reg == S_IDLE);
    assign stat.res_valid = (state_reg == S_OUT);
    assign res            = res_reg;

    always_comb
    begin
        state_next  = state_reg;
        clr_next    = clr_reg;
        kind_next   = kind_reg;
        value_next  = value_reg;
        min_next    = min_reg;
        rank_next   = rank_reg;
        here_next   = here_reg;
        cnt_next    = cnt_reg;
        target_next = target_reg;
        other_next  = other_reg;
        res_next    = res_reg;
        vm_raddr    = to_addr(req_v_x);
        pm_raddr    = to_addr(XW'(req_data.min_count));
        vm_waddr    = '0;
        pm_waddr    = '0;
        vm_wdata    = '0;
        pm_wdata    = '0;
        vm_we_pos   = 1'b0;
        vm_we_cnt   = 1'b0;
        pm_we_val   = 1'b0;
        pm_we_bs    = 1'b0;

        unique case (state_reg)
            S_CLEAR:
            begin
                vm_we_pos    = 1'b1;
                vm_we_cnt    = 1'b1;
                pm_we_val    = 1'b1;
                pm_we_bs     = 1'b1;
                vm_waddr     = clr_reg;
                pm_waddr     = clr_reg;
                vm_wdata.pos = PW'(clr_reg) + PW'(1);
                vm_wdata.cnt = '0;
                pm_wdata.val = PW'(clr_reg) + PW'(1);
                pm_wdata.bs  = PW'(NUM_VALUES + 1);
                if (clr_reg == AW'(NUM_VALUES - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + AW'(1);
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    kind_next  = req_data.kind;
                    value_next = req_data.value;
                    min_next   = req_data.min_count;
                    rank_next  = req_data.rank;
                    priority if (req_data.kind == KIND_QUERY)
                    begin
                        state_next = S_FETCH;
                    end
                    else if ((req_data.kind == KIND_INC || req_data.kind == KIND_DEC) &&
                             req_v_x != '0 && req_v_x <= N_X)
                    begin
                        state_next = S_FETCH;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_FETCH:
            begin
                if (kind_reg == KIND_QUERY)
                begin
                    if (rank_reg == '0 || pos_x > N_X)
                    begin
                        res_next   = '{found: 1'b0, answer_value: '0};
                        state_next = S_OUT;
                    end
                    else
                    begin
                        pm_raddr   = to_addr(pos_x);
                        state_next = S_QREAD;
                    end
                end
                else
                begin
                    here_next = vm_rdata_reg.pos;
                    cnt_next  = vm_rdata_reg.cnt;
                    if ((inc && fetch_cnt_x >= N_X) || (!inc && fetch_cnt_x == '0))
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        pm_raddr   = to_addr(b_fetch_x);
                        state_next = S_BUCKET;
                    end
                end
            end
            S_BUCKET:
            begin
                if (target_ok)
                begin
                    pm_raddr     = to_addr(target_x);
                    pm_we_bs     = 1'b1;
                    pm_waddr     = to_addr(b_x);
                    pm_wdata.bs  = new_bs;
                    vm_we_pos    = 1'b1;
                    vm_we_cnt    = 1'b1;
                    vm_waddr     = to_addr(XW'(value_reg));
                    vm_wdata.pos = PW'(target_x);
                    vm_wdata.cnt = new_cnt;
                    target_next  = PW'(target_x);
                    state_next   = S_SWAP;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_SWAP:
            begin
                other_next   = pm_rdata_reg.val;
                pm_we_val    = 1'b1;
                pm_waddr     = to_addr(XW'(target_reg));
                pm_wdata.val = PW'(value_reg);
                vm_we_pos    = 1'b1;
                vm_waddr     = to_addr(XW'(pm_rdata_reg.val));
                vm_wdata.pos = here_reg;
                state_next   = S_FIX;
            end
            S_FIX:
            begin
                pm_we_val    = 1'b1;
                pm_waddr     = to_addr(XW'(here_reg));
                pm_wdata.val = other_reg;
                state_next   = S_IDLE;
            end
            S_QREAD:
            begin
                res_next   = '{found: 1'b1, answer_value: FIELD_W'(pm_rdata_reg.val)};
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            clr_reg    <= '0;
            kind_reg   <= '0;
            value_reg  <= '0;
            min_reg    <= '0;
            rank_reg   <= '0;
            here_reg   <= '0;
            cnt_reg    <= '0;
            target_reg <= '0;
            other_reg  <= '0;
            res_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            clr_reg    <= clr_next;
            kind_reg   <= kind_next;
            value_reg  <= value_next;
            min_reg    <= min_next;
            rank_reg   <= rank_next;
            here_reg   <= here_next;
            cnt_reg    <= cnt_next;
            target_reg <= target_next;
            other_reg  <= other_next;
            res_reg    <= res_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (vm_we_pos)
        begin
            vm_mem[vm_waddr].pos <= vm_wdata.pos;
        end
        if (vm_we_cnt)
        begin
            vm_mem[vm_waddr].cnt <= vm_wdata.cnt;
        end
        vm_rdata_reg <= vm_mem[vm_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (pm_we_val)
        begin
            pm_mem[pm_waddr].val <= pm_wdata.val;
        end
        if (pm_we_bs)
        begin
            pm_mem[pm_waddr].bs <= pm_wdata.bs;
        end
        pm_rdata_reg <= pm_mem[pm_raddr];
    end

    `FROT_ASSERT_IMP(a_query_no_write, state_reg == S_QREAD || state_reg == S_OUT,
        !(vm_we_pos || vm_we_cnt || pm_we_val || pm_we_bs), "memory write during query")
    `FROT_ASSERT_IMP(a_result_is_query, state_reg == S_OUT, kind_reg == KIND_QUERY,
        "result pending for an update")
    `FROT_ASSERT_IMP(a_target_in_range, state_reg == S_SWAP,
        (target_reg != '0) && (XW'(target_reg) <= N_X), "swap target out of range")

endmodule

>>> rtl/frequency_ordered_rank_table.sv
// ----------------------------------------------------------------------------
// frequency_ordered_rank_table
// Values kept in rising count order with per count bucket starts; counts
// are raised or lowered by swaps, queries return the value at a given rank.
// ----------------------------------------------------------------------------
// Update: fetch, bucket, swap and fix states before the next acceptance (chain of
//   dependent reads through the single read port of each memory); back to idle after
//   fetch if the count saturates; out of range values and unused kinds stay in idle.
// Query: fetch, read and out states, then the output register raises rsp_valid (read
//   skipped when not found); the next request waits until the result is taken.
// Reset: a clearing pass rewrites every entry of both memories; req_ready low.
module frequency_ordered_rank_table #(
    parameter int NUM_VALUES = frot_pkg::NUM_VALUES_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  frot_pkg::req_t req_data,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output frot_pkg::rsp_t rsp_data
);
    import frot_pkg::*;

    frot_stat_t stat;
    rsp_t       res;
    logic       res_take;
    logic       load;
    logic       rsp_valid_reg, rsp_valid_next;
    rsp_t       rsp_data_reg;

    frot_engine #(
        .NUM_VALUES (NUM_VALUES)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_data  (req_data),
        .res_take  (res_take),
        .stat      (stat),
        .res       (res)
    );

    // output register frees the engine while a transaction waits
    assign res_take       = !rsp_valid_reg || rsp_ready;
    assign load           = stat.res_valid && res_take;
    assign rsp_valid_next = load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rsp_data_reg <= res;
        end
    end

    assign req_ready = stat.ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

endmodule

>>> sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench of the frequency ordered rank table
// Predicts every query answer by keeping its own copy of the count ordered
// array, the position index, the counts and the bucket starts. Requests and
// responses move through queues, so each response is checked against the
// oldest answer still due. The run covers directed edge cases, a full count
// saturation of one value, a long response hold-off that fills the block, and
// mostly well formed random traffic under varying idle rates on both sides.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import frot_pkg::*;

    localparam int N         = NUM_VALUES_DEF;
    localparam int LIMIT     = 400000;
    localparam int HOLD_LEN  = 400;
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    req_t req_data  = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    rsp_t rsp_data;

    req_t pending_ops [$];
    rsp_t answers_due [$];

    int unsigned slot_value [0:N+1];
    int unsigned slot_of    [0:N+1];
    int unsigned tally      [0:N+1];
    int unsigned tier_start [0:N+1];

    int send_gap_pct  = 25;
    int recv_gap_pct  = 73;
    int hold_requests = 0;
    int holds_served  = 0;
    int hold_left     = 0;
    int fail_count    = 0;
    int cycles        = 0;

    frequency_ordered_rank_table #(.NUM_VALUES(N)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic void queue_op(input req_t t);
        pending_ops = {pending_ops, t};
    endfunction

    function automatic void clear_table();
        for (int i = 0; i <= N + 1; i++)
        begin
            slot_value[i] = i;
            slot_of[i]    = i;
            tally[i]      = 0;
            tier_start[i] = N + 1;
        end
    endfunction

    function automatic void move_to(input int unsigned v, input int unsigned p);
        int unsigned here;
        int unsigned other;
        here          = slot_of[v];
        other         = slot_value[p];
        slot_value[p] = v;
        slot_value[here] = other;
        slot_of[v]    = p;
        slot_of[other] = here;
    endfunction

    // returns 1 when the request produces a response
    function automatic bit apply_to_table(input req_t r, output rsp_t ans);
        int unsigned v;
        int unsigned c;
        int unsigned p;
        int unsigned start;
        int unsigned pos;
        ans = '0;
        case (r.kind)
            KIND_INC, KIND_DEC:
            begin
                v = 32'(r.value);
                if (v == 0 || v > N)
                    return 1'b0;
                c = tally[v];
                if (r.kind == KIND_INC)
                begin
                    if (c >= N)
                        return 1'b0;
                    p = tier_start[c + 1] - 1;
                    if (p < 1 || p > N)
                        return 1'b0;
                    move_to(v, p);
                    tier_start[c + 1] = p;
                    tally[v] = c + 1;
                end
                else
                begin
                    if (c == 0)
                        return 1'b0;
                    p = tier_start[c];
                    if (p < 1 || p > N)
                        return 1'b0;
                    move_to(v, p);
                    tier_start[c] = p + 1;
                    tally[v] = c - 1;
                end
                return 1'b0;
            end
            KIND_QUERY:
            begin
                if (r.min_count == 0)
                    start = 1;
                else if (r.min_count > N)
                    start = N + 1;
                else
                    start = tier_start[r.min_count];
                if (r.rank == 0)
                    return 1'b1;
                pos = start + r.rank - 1;
                if (pos >= 1 && pos <= N)
                begin
                    ans.found        = 1'b1;
                    ans.answer_value = FIELD_W'(slot_value[pos]);
                end
                return 1'b1;
            end
            default:
                return 1'b0;
        endcase
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin : req_drive
        rsp_t ans;
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req_data  <= '0;
        end
        else
        begin
            if (req_valid && req_ready)
            begin
                if (apply_to_table(req_data, ans))
                    answers_due = {answers_due, ans};
            end
            if (!req_valid || req_ready)
            begin
                if (pending_ops.size() > 0 && $urandom_range(99) >= send_gap_pct)
                begin
                    req_valid <= 1'b1;
                    req_data  <= pending_ops.pop_front();
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    // receiver, with its own hold-off counter
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ready    <= 1'b0;
            hold_left    <= 0;
            holds_served <= 0;
        end
        else if (holds_served != hold_requests)
        begin
            holds_served <= hold_requests;
            hold_left    <= HOLD_LEN;
            rsp_ready    <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            rsp_ready <= 1'b0;
        end
        else
            rsp_ready <= ($urandom_range(99) >= recv_gap_pct);
    end

    // monitor
    always @(posedge clk)
    begin : rsp_check
        rsp_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (answers_due.size() == 0)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected transaction: found=%0b value=%0d",
                             rsp_data.found, rsp_data.answer_value);
            end
            else
            begin
                want = answers_due.pop_front();
                if (rsp_data.found !== want.found
                    || rsp_data.answer_value !== want.answer_value)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("mismatch: found exp %0b got %0b, value exp %0d got %0d",
                                 want.found, rsp_data.found,
                                 want.answer_value, rsp_data.answer_value);
                end
            end
        end
    end

    function automatic req_t op(input logic [KIND_W-1:0] k, input int v,
                                input int m, input int r);
        req_t t;
        t.kind      = k;
        t.value     = FIELD_W'(v);
        t.min_count = FIELD_W'(m);
        t.rank      = FIELD_W'(r);
        return t;
    endfunction

    function automatic int pick_value();
        int s;
        s = $urandom_range(99);
        if (s < 85)
            return $urandom_range(1, 16);
        else if (s < 97)
            return $urandom_range(1, N);
        else
            return $urandom_range(N - 4, N);
    endfunction

    function automatic int pick_min();
        int s;
        s = $urandom_range(99);
        if (s < 70)
            return $urandom_range(0, 24);
        else if (s < 80)
            return 0;
        else if (s < 92)
            return $urandom_range(0, 2047);
        else
            return $urandom_range(N - 1, N + 1);
    endfunction

    function automatic int pick_rank();
        int s;
        s = $urandom_range(99);
        if (s < 75)
            return $urandom_range(1, 24);
        else if (s < 85)
            return $urandom_range(N - 20, N + 2);
        else if (s < 95)
            return $urandom_range(0, 2047);
        else
            return 0;
    endfunction

    task automatic add_random(input int n);
        int s;
        repeat (n)
        begin
            s = $urandom_range(99);
            if (s < 45)
                queue_op(op(KIND_INC, pick_value(), 0, 0));
            else if (s < 65)
                queue_op(op(KIND_DEC, pick_value(), 0, 0));
            else if (s < 93)
                queue_op(op(KIND_QUERY, $urandom_range(0, 2047),
                            pick_min(), pick_rank()));
            else
                queue_op(op(KIND_W'($urandom_range(3)), $urandom_range(0, 2047),
                            $urandom_range(0, 2047), $urandom_range(0, 2047)));
        end
    endtask

    task automatic drain();
        do
            @(negedge clk);
        while (pending_ops.size() != 0 || req_valid || answers_due.size() != 0);
    endtask

    initial
    begin
        clear_table();

        // directed edge cases
        queue_op(op(KIND_QUERY, 0, 0, 1));
        queue_op(op(KIND_QUERY, 0, 0, N));
        queue_op(op(KIND_QUERY, 0, 0, N + 1));
        queue_op(op(KIND_QUERY, 0, 1, 1));
        queue_op(op(KIND_QUERY, 0, 0, 0));
        queue_op(op(KIND_QUERY, 0, N + 1, 1));
        queue_op(op(KIND_QUERY, 2047, 2047, 2047));
        queue_op(op(KIND_INC, 1, 0, 0));
        queue_op(op(KIND_INC, N, 0, 0));
        queue_op(op(KIND_INC, 1, 0, 0));
        queue_op(op(KIND_INC, 5, 0, 0));
        queue_op(op(KIND_DEC, 5, 0, 0));
        queue_op(op(KIND_DEC, 7, 0, 0));
        queue_op(op(KIND_INC, 0, 0, 0));
        queue_op(op(KIND_INC, N + 1, 0, 0));
        queue_op(op(KIND_DEC, 2047, 2047, 2047));
        queue_op(op(KIND_DEC, 0, 0, 0));
        queue_op(op(KIND_UNUSED, 2047, 2047, 2047));
        queue_op(op(KIND_QUERY, 0, 1, 1));
        queue_op(op(KIND_QUERY, 0, 1, 2));
        queue_op(op(KIND_QUERY, 0, 1, 3));
        queue_op(op(KIND_QUERY, 0, 2, 1));
        queue_op(op(KIND_QUERY, 0, 0, N));
        queue_op(op(KIND_QUERY, 0, 0, 2047));
        queue_op(op(KIND_QUERY, 0, N, 1));

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        add_random(25);
        drain();

        // sender idles more; receiver holds off while queries keep coming
        send_gap_pct  = 73;
        recv_gap_pct  = 25;
        hold_requests = hold_requests + 1;
        repeat (30)
            queue_op(op(KIND_QUERY, 0, $urandom_range(0, 3),
                        $urandom_range(1, 40)));
        add_random(20);
        drain();

        // no idling: drive one value to full count and past it
        send_gap_pct = 0;
        recv_gap_pct = 0;
        repeat (N + 6)
            queue_op(op(KIND_INC, 3, 0, 0));
        queue_op(op(KIND_QUERY, 0, N, 1));
        queue_op(op(KIND_QUERY, 0, N, 2));
        queue_op(op(KIND_QUERY, 0, N - 1, 1));
        repeat (5)
            queue_op(op(KIND_DEC, 3, 0, 0));
        queue_op(op(KIND_QUERY, 0, N - 5, 1));
        queue_op(op(KIND_QUERY, 0, N - 4, 1));
        add_random(10);
        drain();

        repeat (20) @(posedge clk);
        if (fail_count == 0 && answers_due.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
